### sv/imh_pkg.sv
// Shared types, constants and codes of the indexed min-heap.
package imh_pkg;

  localparam int ID_N = 256;
  localparam int CAPACITY_DEF = 256;
  localparam int CNT_W = 9;
  localparam int IDX_W = 9;
  localparam int ID_W = 8;
  localparam int PRIO_W = 32;
  localparam logic [CNT_W-1:0] ABSENT_MARK = 9'd256;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_ABSENT     = 3'd3,
    ST_NOT_LOWER  = 3'd4,
    ST_PRESENT    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DEC_RD,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } heap_wr_t;

  typedef struct packed {
    logic             en;
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] slot;
  } pos_wr_t;

endpackage

### sv/imh_heap_mem.sv
// Heap slot memory: one write port and two registered read ports.
module imh_heap_mem #(
  parameter int DEPTH  = imh_pkg::CAPACITY_DEF,
  parameter int SLOT_W = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic [imh_pkg::IDX_W-1:0] rd_a_addr_i,
  input  logic [imh_pkg::IDX_W-1:0] rd_b_addr_i,
  output imh_pkg::entry_t          rd_a_o,
  output imh_pkg::entry_t          rd_b_o,
  input  imh_pkg::heap_wr_t        wr_i
);

  imh_pkg::entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[SLOT_W-1:0]] <= wr_i.data;
    end
    rd_a_o <= mem_q[rd_a_addr_i[SLOT_W-1:0]];
    rd_b_o <= mem_q[rd_b_addr_i[SLOT_W-1:0]];
  end

endmodule

### sv/imh_pos_table.sv
// Position table: heap slot of every id, with valid bits that reset marks absent.
module imh_pos_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [imh_pkg::ID_W-1:0]  rd_id_i,
  output logic [imh_pkg::CNT_W-1:0] rd_slot_o,
  input  imh_pkg::pos_wr_t          wr_i,
  input  logic                      clr_en_i,
  input  logic [imh_pkg::ID_W-1:0]  clr_id_i
);

  logic [imh_pkg::IDX_W-1:0] mem_q [imh_pkg::ID_N];
  logic [imh_pkg::ID_N-1:0]  valid_q;
  logic [imh_pkg::IDX_W-1:0] data_q;
  logic                      rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.id] <= wr_i.slot;
    end
    data_q <= mem_q[rd_id_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[rd_id_i];
      if (wr_i.en) begin
        valid_q[wr_i.id] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_id_i] <= 1'b0;
      end
    end
  end

  assign rd_slot_o = rvalid_q ? imh_pkg::CNT_W'(data_q) : imh_pkg::ABSENT_MARK;

endmodule

### sv/indexed_min_heap.sv
// Top level of the indexed min-heap: command sequencer around the two memories.
//
// One command enters on the slave stream: s_tuser_i carries the command code, s_tdata_i
// the priority and the item id. Each command returns exactly one result transaction on
// the master stream with the extracted id, a status code, the presence flag of the named
// id after the command and the entry count after the command.
// Commands are handled one at a time. A presence query or a command refused at lookup
// passes from the lookup state to the done state, which loads the output register once it
// is free and returns to idle; a decrease refused as not lower first passes the decrease read state.
// An insert or a priority decrease sifts up with a check state and a compare state per
// level, an extract sifts down with a read state and a compare state per level (both
// children are read at once through the two read ports of the slot memory). The slot
// memory reads are registered, so each level needs its own read and compare states.
// A finished result waits in the output register while the block is ready again; a
// further result waits in its done state until the receiver takes the held one, so a
// stalled receiver stops the input side after one pending result.
// Reset empties the heap and marks every id absent at once through valid bits; no
// clearing pass is needed.
module indexed_min_heap #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [31:0] priority_req, [39:32] item_id
  input  logic [39:0] s_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] out_id, [10:8] status, [11] present, [20:12] count, [23:21] zero
  output logic [23:0] m_tdata_o
);

  localparam int HEAP_DEPTH = (CAPACITY < imh_pkg::ID_N) ? CAPACITY : imh_pkg::ID_N;
  localparam int SLOT_W = $clog2(HEAP_DEPTH);
  localparam logic [imh_pkg::CNT_W-1:0] LIMIT = imh_pkg::CNT_W'(HEAP_DEPTH);

  imh_pkg::state_e state_q, state_d;
  imh_pkg::cmd_e   cmd_q, cmd_d;
  logic signed [imh_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [imh_pkg::ID_W-1:0]  id_q, id_d;
  imh_pkg::entry_t           cur_q, cur_d;
  logic [imh_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [imh_pkg::CNT_W-1:0] cnt_q, cnt_d;
  imh_pkg::status_e          status_q, status_d;
  logic [imh_pkg::ID_W-1:0]  out_id_q, out_id_d;
  logic                      present_q, present_d;
  logic                      m_valid_q, m_valid_d;
  logic [23:0]               m_data_q, m_data_d;

  logic [imh_pkg::IDX_W-1:0] hrd_a_addr, hrd_b_addr;
  imh_pkg::entry_t           hrd_a, hrd_b;
  imh_pkg::heap_wr_t         hwr;
  imh_pkg::pos_wr_t          pwr;
  logic                      pclr_en;
  logic [imh_pkg::ID_W-1:0]  pclr_id;
  logic [imh_pkg::CNT_W-1:0] pos_slot;
  logic                      pos_here;

  logic [imh_pkg::IDX_W:0]   left_idx, right_idx;
  logic                      left_ok, right_ok, take_left, take_right;
  logic [imh_pkg::IDX_W-1:0] parent_idx;

  imh_heap_mem #(
    .DEPTH  (HEAP_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_heap (
    .clk_i       (clk_i),
    .rd_a_addr_i (hrd_a_addr),
    .rd_b_addr_i (hrd_b_addr),
    .rd_a_o      (hrd_a),
    .rd_b_o      (hrd_b),
    .wr_i        (hwr)
  );

  imh_pos_table u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_id_i   (id_d),
    .rd_slot_o (pos_slot),
    .wr_i      (pwr),
    .clr_en_i  (pclr_en),
    .clr_id_i  (pclr_id)
  );

  assign pos_here   = pos_slot < cnt_q;
  assign left_idx   = {idx_q, 1'b1};
  assign right_idx  = left_idx + 1'b1;
  assign left_ok    = left_idx < {1'b0, cnt_q};
  assign right_ok   = right_idx < {1'b0, cnt_q};
  assign parent_idx = (idx_q - 1'b1) >> 1;
  assign take_left  = left_ok && (hrd_a.prio < cur_q.prio);
  assign take_right = right_ok && (hrd_b.prio < (take_left ? hrd_a.prio : cur_q.prio));

  assign s_tready_o = (state_q == imh_pkg::S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    prio_d     = prio_q;
    id_d       = id_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    out_id_d   = out_id_q;
    present_d  = present_q;
    m_valid_d  = m_valid_q && !m_tready_i;
    m_data_d   = m_data_q;
    hrd_a_addr = idx_q;
    hrd_b_addr = idx_q;
    hwr        = '0;
    pwr        = '0;
    pclr_en    = 1'b0;
    pclr_id    = out_id_q;

    case (state_q)
      imh_pkg::S_IDLE: begin
        hrd_a_addr = '0;
        hrd_b_addr = imh_pkg::IDX_W'(cnt_q - 1'b1);
        if (s_tvalid_i) begin
          cmd_d     = imh_pkg::cmd_e'(s_tuser_i);
          prio_d    = s_tdata_i[31:0];
          id_d      = s_tdata_i[39:32];
          status_d  = imh_pkg::ST_OK;
          out_id_d  = '0;
          state_d   = imh_pkg::S_LOOK;
        end
      end
      imh_pkg::S_LOOK: begin
        present_d = pos_here;
        state_d   = imh_pkg::S_DONE;
        case (cmd_q)
          imh_pkg::CMD_INSERT: begin
            if (cnt_q >= LIMIT) begin
              status_d = imh_pkg::ST_FULL;
            end else if (pos_here) begin
              status_d = imh_pkg::ST_PRESENT;
            end else begin
              cur_d     = '{prio: prio_q, id: id_q};
              idx_d     = imh_pkg::IDX_W'(cnt_q);
              cnt_d     = cnt_q + 1'b1;
              present_d = 1'b1;
              state_d   = imh_pkg::S_UP_CHK;
            end
          end
          imh_pkg::CMD_EXTRACT: begin
            if (cnt_q == '0) begin
              status_d = imh_pkg::ST_EMPTY;
            end else begin
              out_id_d  = hrd_a.id;
              pclr_en   = 1'b1;
              pclr_id   = hrd_a.id;
              present_d = pos_here && (id_q != hrd_a.id);
              cnt_d     = cnt_q - 1'b1;
              if (cnt_q != 9'd1) begin
                cur_d   = hrd_b;
                idx_d   = '0;
                state_d = imh_pkg::S_DN_RD;
              end
            end
          end
          imh_pkg::CMD_DECREASE: begin
            if (!pos_here) begin
              status_d = imh_pkg::ST_ABSENT;
            end else begin
              idx_d      = imh_pkg::IDX_W'(pos_slot);
              hrd_a_addr = imh_pkg::IDX_W'(pos_slot);
              state_d    = imh_pkg::S_DEC_RD;
            end
          end
          default: begin
          end
        endcase
      end
      imh_pkg::S_DEC_RD: begin
        if (hrd_a.prio <= prio_q) begin
          status_d = imh_pkg::ST_NOT_LOWER;
          state_d  = imh_pkg::S_DONE;
        end else begin
          cur_d   = '{prio: prio_q, id: id_q};
          state_d = imh_pkg::S_UP_CHK;
        end
      end
      imh_pkg::S_UP_CHK: begin
        hrd_a_addr = parent_idx;
        if (idx_q == '0) begin
          hwr     = '{en: 1'b1, addr: idx_q, data: cur_q};
          pwr     = '{en: 1'b1, id: cur_q.id, slot: idx_q};
          state_d = imh_pkg::S_DONE;
        end else begin
          state_d = imh_pkg::S_UP_CMP;
        end
      end
      imh_pkg::S_UP_CMP: begin
        if (hrd_a.prio > cur_q.prio) begin
          // The parent moves down into the hole and the hole climbs one level.
          hwr     = '{en: 1'b1, addr: idx_q, data: hrd_a};
          pwr     = '{en: 1'b1, id: hrd_a.id, slot: idx_q};
          idx_d   = parent_idx;
          state_d = imh_pkg::S_UP_CHK;
        end else begin
          hwr     = '{en: 1'b1, addr: idx_q, data: cur_q};
          pwr     = '{en: 1'b1, id: cur_q.id, slot: idx_q};
          state_d = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_DN_RD: begin
        hrd_a_addr = imh_pkg::IDX_W'(left_idx);
        hrd_b_addr = imh_pkg::IDX_W'(right_idx);
        if (!left_ok) begin
          hwr     = '{en: 1'b1, addr: idx_q, data: cur_q};
          pwr     = '{en: 1'b1, id: cur_q.id, slot: idx_q};
          state_d = imh_pkg::S_DONE;
        end else begin
          state_d = imh_pkg::S_DN_CMP;
        end
      end
      imh_pkg::S_DN_CMP: begin
        if (take_right) begin
          hwr     = '{en: 1'b1, addr: idx_q, data: hrd_b};
          pwr     = '{en: 1'b1, id: hrd_b.id, slot: idx_q};
          idx_d   = imh_pkg::IDX_W'(right_idx);
          state_d = imh_pkg::S_DN_RD;
        end else if (take_left) begin
          hwr     = '{en: 1'b1, addr: idx_q, data: hrd_a};
          pwr     = '{en: 1'b1, id: hrd_a.id, slot: idx_q};
          idx_d   = imh_pkg::IDX_W'(left_idx);
          state_d = imh_pkg::S_DN_RD;
        end else begin
          hwr     = '{en: 1'b1, addr: idx_q, data: cur_q};
          pwr     = '{en: 1'b1, id: cur_q.id, slot: idx_q};
          state_d = imh_pkg::S_DONE;
        end
      end
      imh_pkg::S_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, cnt_q, present_q, status_q, out_id_q};
          state_d   = imh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = imh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= imh_pkg::S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    prio_q    <= prio_d;
    id_q      <= id_d;
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    out_id_q  <= out_id_d;
    present_q <= present_d;
    m_data_q  <= m_data_d;
  end

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LIMIT)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imh_pkg::S_IDLE) |-> (!hwr.en && !pwr.en && !pclr_en))
    else $error("memory write while idle");

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == imh_pkg::S_LOOK))
    else $error("accepted command not looked up");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(state_q == imh_pkg::S_DONE))
    else $error("result raised outside done state");

endmodule

### sim/imh_checker.sv
// Result checker of the indexed min-heap: predicts every command and compares the results.
module imh_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Members run from the highest bit down, matching the result tdata layout.
  typedef struct packed {
    logic [imh_pkg::CNT_W-1:0] count;
    logic                      present;
    imh_pkg::status_e          status;
    logic [imh_pkg::ID_W-1:0]  out_id;
  } heap_result_t;

  logic signed [imh_pkg::PRIO_W-1:0] heap_prio[imh_pkg::ID_N];
  logic [imh_pkg::ID_W-1:0]          heap_id[imh_pkg::ID_N];
  logic [imh_pkg::CNT_W-1:0]         id_slot[imh_pkg::ID_N];
  int                                heap_size;
  heap_result_t                      expected_q[$];

  assign pending_o = expected_q.size();

  function automatic void swap_entries(int a, int b);
    logic signed [imh_pkg::PRIO_W-1:0] tp;
    logic [imh_pkg::ID_W-1:0] ti;
    tp = heap_prio[a]; ti = heap_id[a];
    heap_prio[a] = heap_prio[b]; heap_id[a] = heap_id[b];
    heap_prio[b] = tp; heap_id[b] = ti;
    id_slot[heap_id[a]] = a[imh_pkg::CNT_W-1:0];
    id_slot[heap_id[b]] = b[imh_pkg::CNT_W-1:0];
  endfunction

  function automatic void bubble_up(int i);
    int par;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (heap_prio[par] <= heap_prio[i]) break;
      swap_entries(par, i);
      i = par;
    end
  endfunction

  function automatic void bubble_down(int i);
    int l, r, s;
    while (i < heap_size) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < heap_size && heap_prio[l] < heap_prio[s]) s = l;
      if (r < heap_size && heap_prio[r] < heap_prio[s]) s = r;
      if (s == i) break;
      swap_entries(s, i);
      i = s;
    end
  endfunction

  function automatic heap_result_t apply_command(imh_pkg::cmd_e cmd,
                                                 logic signed [imh_pkg::PRIO_W-1:0] prio,
                                                 logic [imh_pkg::ID_W-1:0] id);
    heap_result_t res;
    int last, pos;
    res = '0;
    res.status = imh_pkg::ST_OK;
    case (cmd)
      imh_pkg::CMD_INSERT: begin
        if (heap_size >= imh_pkg::CAPACITY_DEF) begin
          res.status = imh_pkg::ST_FULL;
        end else if (id_slot[id] < heap_size) begin
          res.status = imh_pkg::ST_PRESENT;
        end else begin
          heap_prio[heap_size] = prio;
          heap_id[heap_size] = id;
          id_slot[id] = heap_size[imh_pkg::CNT_W-1:0];
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      imh_pkg::CMD_EXTRACT: begin
        if (heap_size == 0) begin
          res.status = imh_pkg::ST_EMPTY;
        end else begin
          last = heap_size - 1;
          res.out_id = heap_id[0];
          id_slot[heap_id[0]] = imh_pkg::ABSENT_MARK;
          if (last > 0) begin
            heap_prio[0] = heap_prio[last];
            heap_id[0] = heap_id[last];
            id_slot[heap_id[0]] = '0;
          end
          heap_size = last;
          bubble_down(0);
        end
      end
      imh_pkg::CMD_DECREASE: begin
        if (id_slot[id] >= heap_size) begin
          res.status = imh_pkg::ST_ABSENT;
        end else begin
          pos = id_slot[id];
          if (heap_prio[pos] <= prio) begin
            res.status = imh_pkg::ST_NOT_LOWER;
          end else begin
            heap_prio[pos] = prio;
            bubble_up(pos);
          end
        end
      end
      default: ;
    endcase
    res.present = id_slot[id] < heap_size;
    res.count = heap_size[imh_pkg::CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    heap_size = 0;
    foreach (id_slot[k]) id_slot[k] = imh_pkg::ABSENT_MARK;
  end

  always @(posedge clk_i) begin
    heap_result_t got, want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(apply_command(imh_pkg::cmd_e'(s_tuser_i), s_tdata_i[31:0],
                                           s_tdata_i[39:32]));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[20:0];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.out_id !== want.out_id) report_mismatch("out_id", got.out_id, want.out_id);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.present !== want.present)
            report_mismatch("present", got.present, want.present);
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
          if (m_tdata_i[23:21] !== 3'b000) report_mismatch("pad bits", m_tdata_i[23:21], 0);
        end
      end
    end
  end
endmodule

### sim/tb_indexed_min_heap.sv
// Testbench top of the indexed min-heap: stimulus, idling, pressure and verdict.
module tb_indexed_min_heap;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = imh_pkg::CMD_QUERY;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  int          fail_count, pending, cycles;
  int          rx_wait = 0;
  bit          hold_off = 1'b0;
  bit          no_stall = 1'b0;

  always #4 clk_i = ~clk_i;

  indexed_min_heap u_top (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata)
  );

  imh_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Sends one command; the gap before it is drawn per item unless no_stall is set.
  // Valid stays high after an accept so that back-to-back items need no second update.
  task automatic send_command(imh_pkg::cmd_e cmd, logic [31:0] prio, logic [7:0] id);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {id, prio};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: draws a wait for every transaction, with a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_wait = no_stall ? 0 : $urandom_range(0, 7);
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= (rx_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    hold_off = 1'b1;
    @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int mode;
    logic [31:0] p;
    logic [7:0] id;
    cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty extract, absent decrease, extremes, duplicates, equal decrease.
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'h00);
    send_command(imh_pkg::CMD_DECREASE, 32'h0, 8'hFF);
    send_command(imh_pkg::CMD_QUERY, 32'hFFFF_FFFF, 8'hFF);
    send_command(imh_pkg::CMD_INSERT, 32'h7FFF_FFFF, 8'hFF);
    send_command(imh_pkg::CMD_INSERT, 32'h8000_0000, 8'h00);
    send_command(imh_pkg::CMD_INSERT, 32'h0, 8'hFF);
    send_command(imh_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'h55);
    send_command(imh_pkg::CMD_INSERT, 32'h0000_0001, 8'hAA);
    send_command(imh_pkg::CMD_DECREASE, 32'h7FFF_FFFF, 8'hFF);
    send_command(imh_pkg::CMD_DECREASE, 32'h7FFF_FFFE, 8'hFF);
    send_command(imh_pkg::CMD_DECREASE, 32'h8000_0000, 8'hAA);
    send_command(imh_pkg::CMD_QUERY, 32'h0, 8'h55);
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'h00);
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'hAA);
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'h55);
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'hFF);
    send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'hFF);
    // Fill to capacity in no-stall bursts, then hit the full refusal and drain.
    wait_drained();
    no_stall = 1'b1;
    for (int k = 0; k < imh_pkg::ID_N; k++) send_command(imh_pkg::CMD_INSERT, $urandom, k[7:0]);
    send_command(imh_pkg::CMD_INSERT, $urandom, 8'($urandom));
    send_command(imh_pkg::CMD_DECREASE, $urandom, 8'($urandom));
    for (int k = 0; k < imh_pkg::ID_N + 1; k++)
      send_command(imh_pkg::CMD_EXTRACT, 32'h0, 8'($urandom));
    wait_drained();
    no_stall = 1'b0;
    // Random mix; a narrow id range keeps hits on present ids frequent.
    for (int n = 0; n < 320; n++) begin
      mode = $urandom_range(0, 9);
      id = (n % 200 < 150) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      p = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 200)) - 100);
      if (mode < 4) send_command(imh_pkg::CMD_INSERT, p, id);
      else if (mode < 6) send_command(imh_pkg::CMD_EXTRACT, $urandom, id);
      else if (mode < 9) send_command(imh_pkg::CMD_DECREASE, p, id);
      else send_command(imh_pkg::CMD_QUERY, p, id);
      if (n == 160) wait_drained();
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
